[design/eptq_pkg.sv]
// Package with the shared types and constants of the position trigger queue.
`timescale 1ns / 1ps
package eptq_pkg;

    localparam int QUEUE_DEPTH = 6;
    localparam int SLOTS       = QUEUE_DEPTH - 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH);
    localparam int POS_W       = 16;
    localparam int DELAY_W     = 15;
    localparam int PEND_W      = 3;

    localparam logic [DELAY_W-1:0] DELAY_BASE_RESET = DELAY_W'(4300 + 250);

    // Configuration register indexes.
    localparam logic REG_DELAY_BASE   = 1'b0;
    localparam logic REG_DELAY_ADJUST = 1'b1;

    // Item codes.
    localparam logic FUNC_DETECT = 1'b0;
    localparam logic FUNC_POLL   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
        logic             motor_busy;
    } t_in_item;

    typedef struct packed {
        logic              pushed;
        logic              dropped_full;
        logic              popped;
        logic              fire_motor;
        logic [PEND_W-1:0] pending;
    } t_out_item;

    typedef struct packed {
        logic             wrap;
        logic [POS_W-1:0] target;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

[design/eptq_cell.sv]
// One queue cell: holds a target entry and takes its upper neighbor's entry on a pop.
`timescale 1ns / 1ps
module eptq_cell
    import eptq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_load_entry,
    input  t_entry    i_next_entry,
    output t_entry    o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_entry;
        end else if (i_ctl.shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

[design/encoder_position_trigger_queue.sv]
// Top level of the position trigger queue: cell chain, fill count, config and output register.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
//  cfg       input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// Every accepted item produces exactly one result item in the next cycle, so the block takes
// one item per cycle unless the output stalls; the single output register sets that figure.
// A new item is accepted while the output register is empty or being drained.
// When the output side stalls, input ready drops until the result is taken.
// Reset (synchronous, active low) empties the queue and restores the delay
// registers; the target cells themselves are not cleared.
//
// The queue is a row of QUEUE_DEPTH-1 cells. The head always sits in cell 0.
// A detection loads the cell just past the last occupied one, and a pop makes
// every cell but the last take its upper neighbor's entry, so only cell 0 is ever compared.
module encoder_position_trigger_queue
    import eptq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [DELAY_W-1:0] i_cfg_data
);

    // Configuration. The sum of both delays is kept in its own register so the
    // item path needs only one adder.
    logic [DELAY_W-1:0] r_base, n_base;
    logic [DELAY_W-1:0] r_adjust, n_adjust;
    logic [POS_W-1:0]   r_dist;

    always_comb begin
        n_base   = r_base;
        n_adjust = r_adjust;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DELAY_BASE:   n_base   = i_cfg_data;
                REG_DELAY_ADJUST: n_adjust = i_cfg_data;
                default:          n_base   = r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= DELAY_BASE_RESET;
            r_adjust <= '0;
            r_dist   <= POS_W'(DELAY_BASE_RESET);
        end else begin
            r_base   <= n_base;
            r_adjust <= n_adjust;
            r_dist   <= POS_W'(n_base) + POS_W'(n_adjust);
        end
    end

    // Cell chain.
    t_entry    cell_q   [SLOTS];
    t_cell_ctl cell_ctl [SLOTS];
    t_entry    new_entry;
    t_entry    head;

    logic [CNT_W-1:0] r_count, n_count;
    logic             accept, is_poll, empty, full;
    logic             do_push, do_drop, do_pop;
    logic [POS_W:0]   pos_sum;
    logic             high_region, reached, hold_off;

    assign accept  = i_in_valid && o_in_ready;
    assign is_poll = (i_in_data.func == FUNC_POLL);
    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_W'(SLOTS));

    // A carry out of position + distance means the target passed the top of
    // the counter; for a poll it means the counter is still in its high region.
    assign pos_sum     = {1'b0, i_in_data.position} + {1'b0, r_dist};
    assign high_region = pos_sum[POS_W];

    assign new_entry.target = pos_sum[POS_W-1:0];
    assign new_entry.wrap   = high_region;

    assign head     = cell_q[0];
    assign reached  = (i_in_data.position >= head.target);
    assign hold_off = head.wrap && high_region;

    assign do_push = accept && !is_poll && !full;
    assign do_drop = accept && !is_poll && full;
    assign do_pop  = accept && is_poll && !empty && !hold_off && reached;

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_entry next_entry;

        if (g == SLOTS - 1) begin : g_last
            assign next_entry = cell_q[g];
        end else begin : g_mid
            assign next_entry = cell_q[g+1];
        end

        assign cell_ctl[g].load  = do_push && (r_count == CNT_W'(g));
        assign cell_ctl[g].shift = do_pop;

        eptq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_load_entry (new_entry),
            .i_next_entry (next_entry),
            .o_entry      (cell_q[g])
        );
    end

    // Output register.
    logic      r_out_valid;
    t_out_item r_out_data;

    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.pushed       <= do_push;
            r_out_data.dropped_full <= do_drop;
            r_out_data.popped       <= do_pop;
            r_out_data.fire_motor   <= do_pop && !i_in_data.motor_busy;
            r_out_data.pending      <= PEND_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[design/eptq_checker.sv]
// Port-level checker for the position trigger queue, bound to the top level.
`timescale 1ns / 1ps
module eptq_checker
    import eptq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_in_item           i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_item          o_out_data,
    input logic               i_cfg_we,
    input logic               i_cfg_idx,
    input logic [DELAY_W-1:0] i_cfg_data
);

    // Every accepted item yields a result in the next cycle.
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item produced no result");

    // A detection is either stored or dropped, never both and never neither.
    a_detect_outcome : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.func == FUNC_DETECT
        |=> (o_out_data.pushed ^ o_out_data.dropped_full) && !o_out_data.popped)
        else $error("detection result flags inconsistent");

    // The motor fires only on a pop.
    a_fire_needs_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fire_motor |-> o_out_data.popped)
        else $error("motor fired without a pop");

    // After a store the queue cannot be empty.
    a_push_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pushed |-> o_out_data.pending != '0)
        else $error("stored detection but nothing pending");

    // A stalled result holds.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind encoder_position_trigger_queue eptq_checker u_eptq_checker (.*);
